// ===== sv/tcw_pkg.sv =====
// Text console writer: shared constants, command and register codes,
// and the cell packing function. No dependencies.
package tcw_pkg;

    localparam logic [7:0]  CH_NEWLINE = 8'd10;
    localparam logic [7:0]  CH_SPACE   = 8'd32;
    localparam logic [15:0] RESET_CELL = 16'h0720;

    localparam logic CMD_PUT  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_FG = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BG = 2'd1;

    typedef logic [15:0] t_cell;
    typedef logic [3:0]  t_colour;

    // char in the low byte, attribute = fg | bg << 4 in the high byte
    function automatic t_cell make_cell(logic [7:0] ch, t_colour fg, t_colour bg);
        make_cell = {bg, fg, ch};
    endfunction

endpackage

// ===== sv/text_console_writer.sv =====
// Text console writer top level: cursor, colour registers, sequencer for
// clear and scroll passes, output register. Uses tcw_pkg and tcw_ram.
//
// A put word that neither wraps past the last row nor is a newline on it
// has its result registered in the cycle after it is accepted; a read word
// first passes the registered RAM read in the READ state. A scroll copies
// the store up one row through the RAM, one cell a cycle, then fills the
// bottom row before its result appears. After reset a clearing pass writes
// every one of the COLS*ROWS cells to a gray space, one a cycle, before the
// first word is accepted; configuration writes are taken at any time.
module text_console_writer #(
    parameter int unsigned COLS = 80,
    parameter int unsigned ROWS = 25
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [3:0]  i_cfg_data,
    // input words
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_command,
    input  logic [7:0]  i_char_code,
    input  logic [6:0]  i_read_col,
    input  logic [4:0]  i_read_row,
    // result words
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_cell_entry,
    output logic [6:0]  o_cursor_col,
    output logic [4:0]  o_cursor_row,
    output logic        o_scrolled
);

    localparam int unsigned TOTAL = COLS * ROWS;
    localparam int unsigned AW    = $clog2(TOTAL);
    localparam int unsigned CW    = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int unsigned RW    = $clog2(ROWS);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_READ   = 3'd2;
    localparam logic [2:0] ST_SCROLL = 3'd3;
    localparam logic [2:0] ST_BOTTOM = 3'd4;

    logic [2:0]          r_state;
    logic [AW-1:0]       r_ptr;       // clear / bottom-row write pointer
    logic [AW-1:0]       r_src;       // scroll read pointer
    logic [AW-1:0]       r_cp_addr;   // destination of the copy in flight
    logic                r_cp_v;
    logic [CW-1:0]       r_col;
    logic [RW-1:0]       r_row;
    tcw_pkg::t_colour    r_fg;
    tcw_pkg::t_colour    r_bg;
    logic                r_ov;
    logic [15:0]         r_cell;
    logic [6:0]          r_ocol;
    logic [4:0]          r_orow;
    logic                r_oscr;
    logic                r_rd_ok;

    logic                we;
    logic [AW-1:0]       waddr;
    tcw_pkg::t_cell      wdata;
    logic [AW-1:0]       raddr;
    tcw_pkg::t_cell      rdata;

    logic                acc;
    logic                out_take;
    logic                is_put;
    logic                is_nl;
    logic [CW:0]         col_inc;
    logic                wrap;
    logic                last_row;
    logic                adv_line;
    logic                rd_in_range;
    logic [AW-1:0]       cur_addr;
    logic [AW-1:0]       rd_addr;
    tcw_pkg::t_cell      blank;
    logic [CW-1:0]       n_col;
    logic [RW-1:0]       n_row;

    tcw_ram #(
        .WIDTH(16),
        .DEPTH(TOTAL)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    assign o_cfg_ready = 1'b1;
    assign out_take    = r_ov && i_out_ready;
    assign o_in_ready  = (r_state == ST_IDLE) && (!r_ov || i_out_ready);
    assign acc         = i_in_valid && o_in_ready;

    assign is_put   = (i_command == tcw_pkg::CMD_PUT);
    assign is_nl    = (i_char_code == tcw_pkg::CH_NEWLINE);
    assign col_inc  = {1'b0, r_col} + (CW+1)'(1);
    assign wrap     = (col_inc == (CW+1)'(COLS));
    assign last_row = (r_row == RW'(ROWS - 1));
    assign adv_line = is_nl || wrap;

    assign rd_in_range = (32'(i_read_col) < COLS) && (32'(i_read_row) < ROWS);
    assign cur_addr    = AW'(32'(r_row) * COLS + 32'(r_col));
    assign rd_addr     = AW'(32'(i_read_row) * COLS + 32'(i_read_col));
    assign blank       = tcw_pkg::make_cell(tcw_pkg::CH_SPACE, r_fg, r_bg);

    // cursor after a put word
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (adv_line) begin
            n_col = '0;
            if (!last_row) begin
                n_row = r_row + RW'(1);
            end
        end else begin
            n_col = col_inc[CW-1:0];
        end
    end

    // RAM port selection
    always_comb begin
        we    = 1'b0;
        waddr = r_ptr;
        wdata = tcw_pkg::RESET_CELL;
        raddr = rd_addr;
        unique case (r_state)
            ST_CLEAR: begin
                we = 1'b1;
            end
            ST_IDLE: begin
                we    = acc && is_put && !is_nl;
                waddr = cur_addr;
                wdata = tcw_pkg::make_cell(i_char_code, r_fg, r_bg);
            end
            ST_SCROLL: begin
                raddr = r_src;
                we    = r_cp_v;
                waddr = r_cp_addr;
                wdata = rdata;
            end
            ST_BOTTOM: begin
                // the last copy drains first, then the bottom row fills
                we = 1'b1;
                if (r_cp_v) begin
                    waddr = r_cp_addr;
                    wdata = rdata;
                end else begin
                    wdata = blank;
                end
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_ptr   <= '0;
            r_cp_v  <= 1'b0;
            r_col   <= '0;
            r_row   <= '0;
            r_fg    <= '0;
            r_bg    <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == tcw_pkg::CFG_FG) begin
                    r_fg <= i_cfg_data;
                end else if (i_cfg_index == tcw_pkg::CFG_BG) begin
                    r_bg <= i_cfg_data;
                end
            end

            if (out_take) begin
                r_ov <= 1'b0;
            end

            unique case (r_state)
                ST_CLEAR: begin
                    r_ptr <= r_ptr + AW'(1);
                    if (r_ptr == AW'(TOTAL - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (acc) begin
                        if (!is_put) begin
                            r_state <= ST_READ;
                        end else begin
                            r_col <= n_col;
                            r_row <= n_row;
                            if (adv_line && last_row) begin
                                r_state <= ST_SCROLL;
                                r_cp_v  <= 1'b0;
                            end else begin
                                r_ov <= 1'b1;
                            end
                        end
                    end
                end
                ST_READ: begin
                    r_ov    <= 1'b1;
                    r_state <= ST_IDLE;
                end
                ST_SCROLL: begin
                    r_cp_v <= 1'b1;
                    if (r_src == AW'(TOTAL - 1)) begin
                        r_state <= ST_BOTTOM;
                        r_ptr   <= AW'((ROWS - 1) * COLS);
                    end
                end
                ST_BOTTOM: begin
                    if (r_cp_v) begin
                        r_cp_v <= 1'b0;
                    end else begin
                        r_ptr <= r_ptr + AW'(1);
                        if (r_ptr == AW'(TOTAL - 1)) begin
                            r_ov    <= 1'b1;
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (acc) begin
                    r_rd_ok <= rd_in_range;
                    r_src   <= AW'(COLS);
                    r_cell  <= '0;
                    r_oscr  <= 1'b0;
                    r_ocol  <= is_put ? 7'(n_col) : 7'(r_col);
                    r_orow  <= is_put ? 5'(n_row) : 5'(r_row);
                end
            end
            ST_READ: begin
                r_cell <= r_rd_ok ? rdata : 16'h0000;
            end
            ST_SCROLL: begin
                r_src     <= r_src + AW'(1);
                r_cp_addr <= r_src - AW'(COLS);
                r_oscr    <= 1'b1;
            end
            default: begin
                r_src <= r_src;
            end
        endcase
    end

    assign o_out_valid  = r_ov;
    assign o_cell_entry = r_cell;
    assign o_cursor_col = r_ocol;
    assign o_cursor_row = r_orow;
    assign o_scrolled   = r_oscr;

endmodule

// ===== sv/tcw_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module tcw_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 2000
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
